>>> rtl/core/bdsp_pkg.sv
// Package for the bounded shortest path engine: request/result structs,
// request kinds, register indexes, controller states and command/status structs. No dependencies.
package bdsp_pkg;

    localparam int DIST_W = 24;
    localparam logic [DIST_W-1:0] DIST_INF = '1;

    typedef enum logic [1:0] {
        KIND_CLEAR = 2'd0,
        KIND_ADD   = 2'd1,
        KIND_RUN   = 2'd2,
        KIND_NOP   = 2'd3
    } t_kind;

    localparam logic REG_LIMIT = 1'b0;
    localparam logic REG_NODES = 1'b1;

    typedef struct packed {
        logic [1:0]  kind;
        logic [5:0]  arc_source;
        logic [5:0]  arc_dest;
        logic [15:0] arc_length;
        logic [5:0]  start_node;
    } t_req;

    typedef struct packed {
        logic [5:0]        node_index;
        logic [DIST_W-1:0] distance;
        logic              reachable;
        logic              last;
    } t_res;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_INIT,
        ST_SCAN,
        ST_PICK,
        ST_ARC_RD,
        ST_ARC_WAIT,
        ST_RELAX,
        ST_EMIT
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic clr_arcs;
        logic add_arc;
        logic init;
        logic scan_rst;
        logic scan_step;
        logic settle;
        logic arc_rst;
        logic arc_rd;
        logic relax;
        logic emit_rst;
        logic emit_step;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic init_done;
        logic scan_done;
        logic found;
        logic arc_done;
        logic emit_done;
    } t_sts;

endpackage

>>> rtl/core/bdsp_ctrl.sv
// Controller state machine of the shortest path engine.
// Depends on bdsp_pkg for states, kinds and the command/status structs.
module bdsp_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_start,
    input  logic [1:0]      i_kind,
    input  bdsp_pkg::t_sts  i_sts,
    output bdsp_pkg::t_cmd  o_cmd,
    output logic            o_busy
);

    bdsp_pkg::t_state r_state, n_state;

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= bdsp_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_busy = (r_state != bdsp_pkg::ST_IDLE);

    // Next state and commands.
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            bdsp_pkg::ST_IDLE: begin
                if (i_start) begin
                    unique case (i_kind)
                        bdsp_pkg::KIND_CLEAR: o_cmd.clr_arcs = 1'b1;
                        bdsp_pkg::KIND_ADD:   o_cmd.add_arc = 1'b1;
                        bdsp_pkg::KIND_RUN: begin
                            o_cmd.init = 1'b1;
                            n_state    = bdsp_pkg::ST_INIT;
                        end
                        default: ;
                    endcase
                end
            end
            bdsp_pkg::ST_INIT: begin
                o_cmd.init = 1'b1;
                if (i_sts.init_done) begin
                    o_cmd.scan_rst = 1'b1;
                    n_state = bdsp_pkg::ST_SCAN;
                end
            end
            bdsp_pkg::ST_SCAN: begin
                o_cmd.scan_step = 1'b1;
                if (i_sts.scan_done) n_state = bdsp_pkg::ST_PICK;
            end
            bdsp_pkg::ST_PICK: begin
                if (i_sts.found) begin
                    o_cmd.settle  = 1'b1;
                    o_cmd.arc_rst = 1'b1;
                    n_state = bdsp_pkg::ST_ARC_RD;
                end else begin
                    o_cmd.emit_rst = 1'b1;
                    n_state = bdsp_pkg::ST_EMIT;
                end
            end
            bdsp_pkg::ST_ARC_RD: begin
                if (i_sts.arc_done) begin
                    o_cmd.scan_rst = 1'b1;
                    n_state = bdsp_pkg::ST_SCAN;
                end else begin
                    o_cmd.arc_rd = 1'b1;
                    n_state = bdsp_pkg::ST_ARC_WAIT;
                end
            end
            bdsp_pkg::ST_ARC_WAIT: n_state = bdsp_pkg::ST_RELAX;
            bdsp_pkg::ST_RELAX: begin
                o_cmd.relax = 1'b1;
                n_state = bdsp_pkg::ST_ARC_RD;
            end
            bdsp_pkg::ST_EMIT: begin
                o_cmd.emit_step = 1'b1;
                if (i_sts.emit_done) n_state = bdsp_pkg::ST_IDLE;
            end
            default: n_state = bdsp_pkg::ST_IDLE;
        endcase
    end

endmodule

>>> rtl/core/bdsp_dp.sv
// Datapath of the shortest path engine: arc memory, distance memory,
// settled flags, minimum scan, relaxation and result output. Uses bdsp_pkg.
module bdsp_dp #(
    parameter int MAX_NODES   = 64,
    parameter int MAX_ARCS    = 1024,
    parameter int LENGTH_BITS = 16
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  bdsp_pkg::t_req              i_req,
    input  logic [bdsp_pkg::DIST_W-1:0] i_limit,
    input  logic [6:0]                  i_nodes,
    input  bdsp_pkg::t_cmd              i_cmd,
    output bdsp_pkg::t_sts              o_sts,
    output logic                        o_res_vld,
    output bdsp_pkg::t_res              o_res
);

    localparam int NW = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
    localparam int CW = $clog2(MAX_NODES + 1);
    localparam int AW = (MAX_ARCS > 1) ? $clog2(MAX_ARCS) : 1;
    localparam int KW = $clog2(MAX_ARCS + 1);
    localparam int DW = bdsp_pkg::DIST_W;
    localparam int ARC_W = 12 + LENGTH_BITS;

    // Effective node count, clamped to 1..MAX_NODES.
    logic [CW-1:0] w_n;
    always_comb begin
        if (i_nodes == 7'd0) w_n = CW'(1);
        else if (32'(i_nodes) > MAX_NODES) w_n = CW'(MAX_NODES);
        else w_n = CW'(i_nodes);
    end

    // Arc memory, written on add, read one entry per relaxation.
    logic [ARC_W-1:0] r_arcs [MAX_ARCS];
    logic [ARC_W-1:0] r_arc_q;
    logic [KW-1:0]    r_arc_cnt;
    logic [KW-1:0]    r_arc_ptr;
    logic             w_lenfit;
    assign w_lenfit = 1'b1;

    always_ff @(posedge i_clk) begin
        if (i_cmd.add_arc && (32'(r_arc_cnt) < MAX_ARCS) && w_lenfit) begin
            r_arcs[r_arc_cnt[AW-1:0]] <= {i_req.arc_source, i_req.arc_dest,
                                          LENGTH_BITS'(i_req.arc_length)};
        end
        if (i_cmd.arc_rd) r_arc_q <= r_arcs[r_arc_ptr[AW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.clr_arcs) begin
            r_arc_cnt <= '0;
        end else if (i_cmd.add_arc && (32'(r_arc_cnt) < MAX_ARCS)) begin
            r_arc_cnt <= r_arc_cnt + KW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.arc_rst) r_arc_ptr <= '0;
        else if (i_cmd.arc_rd) r_arc_ptr <= r_arc_ptr + KW'(1);
    end
    assign o_sts.arc_done = (r_arc_ptr == r_arc_cnt);

    // Distance memory: single write port, one read port; init sweeps it.
    logic [DW-1:0]        r_dist [MAX_NODES];
    logic [DW-1:0]        r_dist_q;
    logic [MAX_NODES-1:0] r_settled;
    logic [CW-1:0]        r_ptr;
    logic                 r_rd_vld;
    logic [NW-1:0]        r_rd_idx;
    logic [NW-1:0]        r_best;
    logic [DW-1:0]        r_best_d;
    logic                 r_found;
    logic [5:0]           r_start;
    logic                 r_first;
    logic [5:0]           w_start;

    logic [NW-1:0] w_rd_addr;
    logic          w_we;
    logic [NW-1:0] w_wa;
    logic [DW-1:0] w_wd;

    // Arc fields of the entry just read.
    logic [5:0]             w_asrc, w_adst;
    logic [LENGTH_BITS-1:0] w_alen;
    logic [DW:0]            w_nd;
    assign {w_asrc, w_adst, w_alen} = r_arc_q;
    assign w_nd = {1'b0, r_best_d} + (DW+1)'(w_alen);

    // A write from the previous relaxation is forwarded to the comparison.
    logic          r_fw_vld;
    logic [NW-1:0] r_fw_idx;
    logic [DW-1:0] r_fw_d;
    logic [DW-1:0] w_dst_d;
    assign w_dst_d = (r_fw_vld && r_fw_idx == w_adst[NW-1:0]) ? r_fw_d : r_dist_q;

    logic w_relax_ok;
    assign w_relax_ok = i_cmd.relax && (w_asrc == 6'(r_best)) &&
                        ({1'b0, w_adst} < 7'(w_n)) &&
                        (w_nd <= {1'b0, i_limit}) && (w_nd < {1'b0, w_dst_d});

    // The first init cycle is the accepting cycle; the start node is taken
    // straight from the request there and held for the rest of the sweep.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_first <= 1'b1;
        else r_first <= !i_cmd.init;
    end

    always_ff @(posedge i_clk) begin
        if (r_first && i_cmd.init) r_start <= i_req.start_node;
    end
    assign w_start = r_first ? i_req.start_node : r_start;

    always_comb begin
        w_we = 1'b0;
        w_wa = '0;
        w_wd = '0;
        if (i_cmd.init) begin
            w_we = 1'b1;
            w_wa = r_ptr[NW-1:0];
            w_wd = ({1'b0, w_start} == 7'(r_ptr) && (7'(w_start) < 7'(w_n)))
                   ? '0 : bdsp_pkg::DIST_INF;
        end else if (w_relax_ok) begin
            w_we = 1'b1;
            w_wa = w_adst[NW-1:0];
            w_wd = w_nd[DW-1:0];
        end
    end

    // Scan and emit sweeps read by node pointer; otherwise the destination of the held arc
    // is read, so its distance is ready in the relax cycle.
    always_comb begin
        if (i_cmd.scan_step || i_cmd.emit_step) w_rd_addr = r_ptr[NW-1:0];
        else w_rd_addr = w_adst[NW-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (w_we) r_dist[w_wa] <= w_wd;
        r_dist_q <= r_dist[w_rd_addr];
    end

    // Node pointer shared by init sweep, scan and output.
    logic w_ptr_rst, w_ptr_inc;
    assign w_ptr_rst = i_cmd.scan_rst || i_cmd.emit_rst ||
                       (i_cmd.init && o_sts.init_done) ||
                       (i_cmd.emit_step && o_sts.emit_done);
    assign w_ptr_inc = i_cmd.init || (i_cmd.scan_step && r_ptr != w_n) ||
                       (i_cmd.emit_step && r_ptr != w_n);
    assign o_sts.init_done = (32'(r_ptr) == MAX_NODES - 1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ptr <= '0;
        end else if (w_ptr_rst) begin
            r_ptr <= '0;
        end else if (w_ptr_inc) begin
            r_ptr <= r_ptr + CW'(1);
        end
    end

    // Scan and emit pipeline: read issued with ptr, compared or emitted in the next cycle.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_vld <= 1'b0;
        end else begin
            r_rd_vld <= (i_cmd.scan_step || i_cmd.emit_step) && (r_ptr != w_n);
        end
        r_rd_idx <= r_ptr[NW-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.scan_rst) begin
            r_found  <= 1'b0;
            r_best_d <= bdsp_pkg::DIST_INF;
            r_best   <= '0;
        end else if (i_cmd.scan_step && r_rd_vld && !r_settled[r_rd_idx] &&
                     r_dist_q < r_best_d) begin
            r_found  <= 1'b1;
            r_best_d <= r_dist_q;
            r_best   <= r_rd_idx;
        end
    end
    assign o_sts.scan_done = (r_ptr == w_n) && !r_rd_vld;
    assign o_sts.found = r_found;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_settled <= '0;
        end else if (i_cmd.init) begin
            r_settled <= '0;
        end else if (i_cmd.settle) begin
            r_settled[r_best] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fw_vld <= 1'b0;
        end else if (i_cmd.arc_rst) begin
            r_fw_vld <= 1'b0;
        end else if (w_relax_ok) begin
            r_fw_vld <= 1'b1;
        end
        if (w_relax_ok) begin
            r_fw_idx <= w_adst[NW-1:0];
            r_fw_d   <= w_nd[DW-1:0];
        end
    end

    // Result output, one node per cycle during the emit sweep.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_res_vld <= 1'b0;
        end else begin
            o_res_vld <= i_cmd.emit_step && r_rd_vld;
        end
        o_res.node_index <= 6'(r_rd_idx);
        o_res.distance   <= r_dist_q;
        o_res.reachable  <= (r_dist_q != bdsp_pkg::DIST_INF);
        o_res.last       <= (CW'(r_rd_idx) + CW'(1) == w_n);
    end
    assign o_sts.emit_done = (r_ptr == w_n) && !r_rd_vld;

endmodule

>>> rtl/core/bounded_dijkstra_shortest_path.sv
// Top level of the bounded shortest path engine.
// Depends on bdsp_pkg, bdsp_ctrl and bdsp_dp.
//
// Clear and add-arc requests are handled in the accepting cycle and leave
// the controller idle. A run first sweeps all MAX_NODES distance entries,
// starting in the accepting cycle, then per settled node does a minimum scan
// and pick and reads and relaxes each stored arc, then a last scan that
// finds nothing, then an output sweep that carries one result per node on
// o_res_vld; busy is high from ST_INIT to the last result. The receiver
// cannot stall, so each result is presented for exactly one cycle. The arc
// memory is only read below the arc count and needs no clearing pass.
module bounded_dijkstra_shortest_path #(
    parameter int MAX_NODES   = 64,
    parameter int MAX_ARCS    = 1024,
    parameter int LENGTH_BITS = 16
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            start,
    output logic            busy,
    input  bdsp_pkg::t_req  i_req,
    output logic            o_res_vld,
    output bdsp_pkg::t_res  o_res,
    input  logic            i_cfg_valid,
    output logic            o_cfg_ready,
    input  logic            i_cfg_index,
    input  logic [23:0]     i_cfg_data
);

    logic [23:0] r_limit;
    logic [6:0]  r_nodes;
    bdsp_pkg::t_cmd w_cmd;
    bdsp_pkg::t_sts w_sts;

    assign o_cfg_ready = 1'b1;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= bdsp_pkg::DIST_INF;
            r_nodes <= 7'd64;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                bdsp_pkg::REG_LIMIT: r_limit <= i_cfg_data;
                bdsp_pkg::REG_NODES: r_nodes <= i_cfg_data[6:0];
                default: ;
            endcase
        end
    end

    bdsp_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_kind  (i_req.kind),
        .i_sts   (w_sts),
        .o_cmd   (w_cmd),
        .o_busy  (busy)
    );

    bdsp_dp #(
        .MAX_NODES   (MAX_NODES),
        .MAX_ARCS    (MAX_ARCS),
        .LENGTH_BITS (LENGTH_BITS)
    ) u_dp (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (i_req),
        .i_limit   (r_limit),
        .i_nodes   (r_nodes),
        .i_cmd     (w_cmd),
        .o_sts     (w_sts),
        .o_res_vld (o_res_vld),
        .o_res     (o_res)
    );

    // Results appear only while a run is in progress.
    a_res_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_vld |-> $past(busy)) else $error("result outside a run");

    // A reachable flag always agrees with the distance.
    a_reach: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_vld |-> (o_res.reachable == (o_res.distance != bdsp_pkg::DIST_INF)))
        else $error("reachable flag mismatch");

endmodule
